/* rtl/core/asc_pkg.sv */
`default_nettype none
package asc_pkg;

  localparam int MAX_HEADER_BYTES = 8;
  localparam int BYTE_W = 8;
  localparam int POS_W = 32;
  localparam int LEN_W = 4;
  localparam int FILL_W = 4;
  localparam int WIN_IDX_W = $clog2(MAX_HEADER_BYTES);
  localparam int HDR_W = MAX_HEADER_BYTES * BYTE_W;
  localparam int END_MARK_LEN = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] END_MARK_FIRST = 8'hFF;
  localparam logic [BYTE_W-1:0] END_MARK_SECOND = 8'hD9;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [LEN_W-1:0] HDR_LEN_RESET = LEN_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_BYTES = 1'b0,
    CFG_HEADER_LENGTH = 1'b1
  } asc_cfg_idx_t;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_END = 1'b1
  } asc_kind_t;

  // newest byte at index 0
  typedef logic [MAX_HEADER_BYTES-1:0][BYTE_W-1:0] asc_win_t;

  typedef struct packed {
    logic [HDR_W-1:0] header_bytes;
    logic [LEN_W-1:0] header_length;
  } asc_cfg_t;

  typedef struct packed {
    logic seeking_end;
    logic [FILL_W-1:0] fill;
    logic [POS_W-1:0] position;
  } asc_scan_t;

  typedef struct packed {
    logic hit;
    asc_kind_t kind;
    logic [POS_W-1:0] offset;
  } asc_result_t;

endpackage
`default_nettype wire

/* rtl/core/asc_in_if.sv */
`default_nettype none
interface asc_in_if import asc_pkg::*; ();
  logic valid;
  logic ready;
  logic [BYTE_W-1:0] data_byte;
  logic stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface
`default_nettype wire

/* rtl/core/asc_out_if.sv */
`default_nettype none
interface asc_out_if import asc_pkg::*; ();
  logic valid;
  logic ready;
  logic match_kind;
  logic [POS_W-1:0] stream_offset;

  modport source (output valid, output match_kind, output stream_offset, input ready);
  modport sink (input valid, input match_kind, input stream_offset, output ready);
endinterface
`default_nettype wire

/* rtl/core/asc_cfg_if.sv */
`default_nettype none
interface asc_cfg_if import asc_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [HDR_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/asc_match.sv */
`default_nettype none
module asc_match import asc_pkg::*; (
  input  asc_win_t    win,
  input  asc_cfg_t    cfg,
  input  asc_scan_t   scan,
  output asc_result_t res
);

  logic [LEN_W-1:0] hlen;
  logic [LEN_W-1:0] wlen;
  logic [LEN_W-1:0] plen;
  logic [MAX_HEADER_BYTES-1:0] lane_ok;
  logic [LEN_W-1:0] lane_pos [MAX_HEADER_BYTES];
  logic [BYTE_W-1:0] lane_want [MAX_HEADER_BYTES];
  logic [POS_W-1:0] base;
  logic [POS_W:0] end_sum;

  always_comb begin
    if (cfg.header_length == '0) begin
      hlen = LEN_W'(1);
    end else if (cfg.header_length > LEN_W'(MAX_HEADER_BYTES)) begin
      hlen = LEN_W'(MAX_HEADER_BYTES);
    end else begin
      hlen = cfg.header_length;
    end
    wlen = (hlen > LEN_W'(END_MARK_LEN)) ? hlen : LEN_W'(END_MARK_LEN);
    plen = scan.seeking_end ? LEN_W'(END_MARK_LEN) : hlen;
  end

  // lane k compares pattern byte k against the window byte k places after the start
  always_comb begin
    for (int k = 0; k < MAX_HEADER_BYTES; k++) begin
      lane_pos[k] = wlen - LEN_W'(1) - LEN_W'(k);
      if (scan.seeking_end) begin
        lane_want[k] = ((k % 2) == 0) ? END_MARK_FIRST : END_MARK_SECOND;
      end else begin
        lane_want[k] = cfg.header_bytes[k*BYTE_W +: BYTE_W];
      end
      lane_ok[k] = (LEN_W'(k) >= plen) ||
                   (win[lane_pos[k][WIN_IDX_W-1:0]] == lane_want[k]);
    end
  end

  always_comb begin
    if (scan.position == POS_MAX) begin
      base = POS_MAX;
    end else begin
      base = scan.position - POS_W'(wlen - LEN_W'(1));
    end
    end_sum = {1'b0, base} + (POS_W+1)'(END_MARK_LEN);
    res.hit = (scan.fill >= wlen) && (&lane_ok);
    res.kind = scan.seeking_end ? KIND_END : KIND_HEADER;
    if (!scan.seeking_end) begin
      res.offset = base;
    end else if (end_sum[POS_W]) begin
      res.offset = POS_MAX;
    end else begin
      res.offset = end_sum[POS_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/alternating_signature_scanner.sv */
`default_nettype none
// Scans a byte stream, one byte per transaction, for a configurable header
// signature (1 to 8 bytes, register 0 holds the bytes with the first in the
// low bits, register 1 the length) and then for the end marker FF D9,
// alternating between the two. A header hit reports its start offset with
// match_kind 0; an end hit reports the offset just past the marker with
// match_kind 1. Offsets saturate at 0xFFFFFFFF. The byte flagged stream_end
// closes the stream and the scan state returns to its reset values.
// Throughput is one byte per clock: the byte is registered on accept and the
// whole window compare runs from that register into the output register. The
// input stalls only while a held result has not been taken and the next byte
// also hits. The user must write configuration only while the scanner is
// idle; the block itself does not enforce this. The write port is always
// ready.
module alternating_signature_scanner import asc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  asc_in_if.sink   in_ch,
  asc_cfg_if.sink  cfg_ch,
  asc_out_if.source out_ch
);

  asc_cfg_t cfg_r;

  logic s1_v_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic s1_last_r;

  asc_win_t win_r;
  asc_win_t win_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic seek_r;

  logic out_v_r;
  asc_kind_t out_kind_r;
  logic [POS_W-1:0] out_off_r;

  asc_scan_t scan;
  asc_result_t res;
  logic advance;
  logic in_take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_bytes <= '0;
      cfg_r.header_length <= HDR_LEN_RESET;
    end else if (cfg_ch.valid) begin
      case (asc_cfg_idx_t'(cfg_ch.index))
        CFG_HEADER_BYTES:  cfg_r.header_bytes <= cfg_ch.data;
        CFG_HEADER_LENGTH: cfg_r.header_length <= cfg_ch.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    win_nxt = {win_r[MAX_HEADER_BYTES-2:0], s1_byte_r};
    fill_nxt = (fill_r < FILL_W'(MAX_HEADER_BYTES)) ? fill_r + FILL_W'(1) : fill_r;
    pos_nxt = (pos_r != POS_MAX) ? pos_r + POS_W'(1) : pos_r;
    scan.seeking_end = seek_r;
    scan.fill = fill_nxt;
    scan.position = pos_r;
  end

  asc_match u_match (
    .win  (win_nxt),
    .cfg  (cfg_r),
    .scan (scan),
    .res  (res)
  );

  // a byte with no hit never waits on the output side
  assign advance = s1_v_r && (!out_v_r || out_ch.ready || !res.hit);
  assign in_ch.ready = !s1_v_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_take) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      pos_r <= '0;
      fill_r <= '0;
      seek_r <= 1'b0;
    end else if (advance) begin
      if (s1_last_r) begin
        win_r <= '0;
        pos_r <= '0;
        fill_r <= '0;
        seek_r <= 1'b0;
      end else begin
        win_r <= win_nxt;
        pos_r <= pos_nxt;
        fill_r <= fill_nxt;
        seek_r <= seek_r ^ res.hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && res.hit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      out_kind_r <= res.kind;
      out_off_r <= res.offset;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.match_kind = out_kind_r;
  assign out_ch.stream_offset = out_off_r;

endmodule
`default_nettype wire

/* rtl/core/asc_checker.sv */
`default_nettype none
module asc_checker import asc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_match_kind,
  input wire logic [POS_W-1:0] out_stream_offset
);

  // a held result keeps its payload until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_kind) &&
                                $stable(out_stream_offset))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // input backpressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // end offsets point past a two byte marker
  a_end_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_match_kind == KIND_END) |-> out_stream_offset >= POS_W'(END_MARK_LEN))
    else $error("end marker offset below marker length");

endmodule

bind alternating_signature_scanner asc_checker u_asc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_match_kind    (out_ch.match_kind),
  .out_stream_offset (out_ch.stream_offset)
);
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import asc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 125;

  typedef struct {
    asc_kind_t kind;
    logic [POS_W-1:0] offset;
  } match_t;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  class match_scoreboard;
    logic [HDR_W-1:0] sig_bytes;
    logic [LEN_W-1:0] sig_len;
    asc_win_t window;
    logic [POS_W-1:0] position;
    bit seeking_end;
    int unsigned fill;
    match_t expected[$];
    int unsigned failures;

    function new();
      sig_bytes = '0;
      sig_len = HDR_LEN_RESET;
      failures = 0;
      rewind();
    endfunction

    function void rewind();
      window = '0;
      position = '0;
      seeking_end = 1'b0;
      fill = 0;
    endfunction

    function void write_register(asc_cfg_idx_t idx, logic [HDR_W-1:0] value);
      case (idx)
        CFG_HEADER_BYTES: sig_bytes = value;
        CFG_HEADER_LENGTH: sig_len = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [BYTE_W-1:0] value, logic last);
      int unsigned hlen, wlen, plen, k;
      logic [POS_W-1:0] cur;
      logic [POS_W:0] off;
      logic [BYTE_W-1:0] got, want;
      bit hit;
      match_t m;
      hlen = 32'(sig_len);
      if (hlen < 1) hlen = 1;
      if (hlen > MAX_HEADER_BYTES) hlen = MAX_HEADER_BYTES;
      wlen = (hlen > END_MARK_LEN) ? hlen : END_MARK_LEN;
      cur = position;
      window = {window[MAX_HEADER_BYTES-2:0], value};
      if (fill < MAX_HEADER_BYTES) fill++;
      if (position != POS_MAX) position = position + 1'b1;
      if (fill >= wlen) begin
        plen = seeking_end ? END_MARK_LEN : hlen;
        hit = 1'b1;
        for (k = 0; k < plen; k++) begin
          got = window[wlen-1-k];
          if (seeking_end) want = (k == 0) ? END_MARK_FIRST : END_MARK_SECOND;
          else want = sig_bytes[8*k +: 8];
          if (got != want) hit = 1'b0;
        end
        if (hit) begin
          // window start lags the newest byte by wlen - 1
          if (cur == POS_MAX) off = {1'b0, POS_MAX};
          else off = {1'b0, cur} - (POS_W+1)'(wlen - 1);
          if (seeking_end) begin
            off = off + (POS_W+1)'(END_MARK_LEN);
            if (off > {1'b0, POS_MAX}) off = {1'b0, POS_MAX};
            m.kind = KIND_END;
          end else begin
            m.kind = KIND_HEADER;
          end
          m.offset = off[POS_W-1:0];
          expected = {expected, m};
          seeking_end = !seeking_end;
        end
      end
      if (last) rewind();
    endfunction

    function void check_match(logic kind, logic [POS_W-1:0] offset);
      match_t m;
      if (expected.size() == 0) begin
        $error("unexpected match: match_kind %0d stream_offset %0d", kind, offset);
        failures++;
        return;
      end
      m = expected.pop_front();
      if (kind !== m.kind) begin
        $error("match_kind: expected %0d, actual %0d", m.kind, kind);
        failures++;
      end
      if (offset !== m.offset) begin
        $error("stream_offset: expected %0d, actual %0d", m.offset, offset);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit steady;
  logic [HDR_W-1:0] sig_now;
  int unsigned sig_len_now;
  int unsigned quiet_cycles = 0;
  match_scoreboard sb = new();

  asc_in_if in_ch();
  asc_out_if out_ch();
  asc_cfg_if cfg_ch();

  alternating_signature_scanner uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .cfg_ch(cfg_ch),
    .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // every transaction is sampled with the values that the block saw at the edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_byte(in_ch.data_byte, in_ch.stream_end);
    if (rst_n && cfg_ch.valid && cfg_ch.ready)
      sb.write_register(asc_cfg_idx_t'(cfg_ch.index), cfg_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_match(out_ch.match_kind, out_ch.stream_offset);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (!steady && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] value, input logic last);
    if (!steady && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= value;
    in_ch.stream_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic push_stream(input byte_q_t bytes);
    int i;
    for (i = 0; i < bytes.size(); i++) push_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic load_config(input logic [HDR_W-1:0] sig, input logic [HDR_W-1:0] len_word);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_HEADER_BYTES;
    cfg_ch.data <= sig;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= CFG_HEADER_LENGTH;
    cfg_ch.data <= len_word;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sig_now = sig;
    sig_len_now = 32'(len_word[LEN_W-1:0]);
    if (sig_len_now < 1) sig_len_now = 1;
    if (sig_len_now > MAX_HEADER_BYTES) sig_len_now = MAX_HEADER_BYTES;
  endtask

  // drop valid, let all matches drain, then cover the pipeline latency
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic scan_bytes(input int unsigned count);
    int unsigned sent, k, n, pick;
    logic [BYTE_W-1:0] value;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) n = sig_len_now;
      else if (pick < 6) n = END_MARK_LEN;
      else n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) begin
        if (pick < 4) begin
          value = sig_now[8*k +: 8];
        end else if (pick < 6) begin
          value = (k == 0) ? END_MARK_FIRST : END_MARK_SECOND;
        end else begin
          case ($urandom_range(0, 7))
            0: value = END_MARK_FIRST;
            1: value = END_MARK_SECOND;
            2: value = '0;
            default: value = BYTE_W'($urandom);
          endcase
        end
        // occasionally break a signature or marker
        if (pick < 6 && $urandom_range(0, 11) == 0) value = BYTE_W'($urandom);
        push_byte(value, $urandom_range(0, 59) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    byte_q_t seq;
    int ph;
    logic [HDR_W-1:0] sig, len_word;
    rst_n = 1'b0;
    steady = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.stream_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_HEADER_BYTES;
    cfg_ch.data = '0;
    sig_now = '0;
    sig_len_now = 32'(HDR_LEN_RESET);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: zero header of three bytes, end marker seen once the window passes it
    seq = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hD9, 8'h55, 8'hAA};
    push_stream(seq);
    settle();

    // one byte header equal to the first marker byte
    load_config(64'h0000_0000_0000_00FF, 64'h1);
    seq = '{8'hFF, 8'hD9, 8'hFF, 8'hD9};
    push_stream(seq);
    settle();

    // length above the maximum, end marker overlapping the header just found
    load_config(64'hFE01_7E00_00D9_FF11, '1);
    seq = '{8'h11, 8'hFF, 8'hD9, 8'h00, 8'h00, 8'h7E, 8'h01, 8'hFE, 8'h55, 8'hAA};
    push_stream(seq);
    settle();

    // zero length is taken as one
    load_config('0, '0);
    seq = '{8'h00, 8'hFF, 8'hD9, 8'h00};
    push_stream(seq);

    // streams run on across phases, so a length change can land mid-stream
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      steady = (ph == PHASES - 1);
      sig = {$urandom, $urandom};
      len_word = {$urandom, $urandom};
      case (ph)
        0: begin
          sig = '1;
          len_word[LEN_W-1:0] = LEN_W'(1);
        end
        1: begin
          sig = '0;
          len_word[LEN_W-1:0] = LEN_W'(MAX_HEADER_BYTES);
        end
        2: len_word[LEN_W-1:0] = '0;
        3: len_word[LEN_W-1:0] = '1;
        4: len_word[LEN_W-1:0] = LEN_W'(END_MARK_LEN);
        default: len_word[LEN_W-1:0] = LEN_W'($urandom_range(0, 15));
      endcase
      load_config(sig, len_word);
      scan_bytes(PHASE_BYTES);
    end
    settle();

    if (sb.failures == 0 && sb.pending() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

/* files.f */
rtl/core/asc_pkg.sv
rtl/core/asc_in_if.sv
rtl/core/asc_out_if.sv
rtl/core/asc_cfg_if.sv
rtl/core/asc_match.sv
rtl/core/alternating_signature_scanner.sv
rtl/core/asc_checker.sv
sim/testbench.sv
